### hw/rtl/wlbf_pkg.sv
// package for the windowed length balance flagger
// widths, segment kind codes, severity codes and controller/datapath structs
`timescale 1ns / 1ps
`default_nettype none

package wlbf_pkg;

    localparam int SUM_W  = 40;
    localparam int FRAC_W = 16;
    localparam int THR_W  = FRAC_W + 1;
    localparam int LEN_W  = 32;
    localparam int KIND_W = 3;
    localparam int SEV_W  = 2;
    localparam int PROD_W = SUM_W + THR_W;
    localparam int CMP_W  = PROD_W + 1;
    localparam int REM_W  = SUM_W + 2;
    localparam int CNT_W  = $clog2(THR_W);

    localparam int IN_DATA_W  = ((KIND_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = 6 * SUM_W + 2 * FRAC_W + SEV_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_COMMON = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SECOND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SIDE   = 3'd3;

    localparam logic [SEV_W-1:0] SEV_NONE   = 2'd0;
    localparam logic [SEV_W-1:0] SEV_NOTICE = 2'd1;
    localparam logic [SEV_W-1:0] SEV_WARN   = 2'd2;
    localparam logic [SEV_W-1:0] SEV_ERROR  = 2'd3;

    localparam logic [1:0] REG_WARN  = 2'd0;
    localparam logic [1:0] REG_ERROR = 2'd1;
    localparam logic [1:0] REG_SPAN  = 2'd2;

    localparam logic [THR_W-1:0] WARN_RESET  = 17'd13107;
    localparam logic [THR_W-1:0] ERROR_RESET = 17'd32768;
    localparam logic [SUM_W-1:0] SPAN_RESET  = 40'd1000000;

    typedef struct packed {
        logic in_take;
        logic acc;
        logic win_reset;
        logic load_win;
        logic load_glob;
        logic step;
        logic out_load;
        logic out_hold;
        logic out_show;
        logic out_last;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        logic             span_hit;
        logic             nonempty;
        logic             eos;
        logic [SEV_W-1:0] sev;
        logic             out_free;
    } t_stat;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - LEN_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/wlbf_ctrl.sv
// controller state machine of the flagger
// sequences accumulate, window check, serial grading and result transfer; uses wlbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wlbf_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    output logic           o_s_tready,
    input  wlbf_pkg::t_stat i_stat,
    output wlbf_pkg::t_cmd  o_cmd
);
    import wlbf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;
    localparam logic [2:0] S_GLD  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(THR_W - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_glob, n_glob;
    logic             r_held, n_held;
    logic             emit;
    logic             close;

    assign o_s_tready = (r_state == S_IDLE);
    assign close      = i_stat.span_hit | i_stat.eos;
    assign emit       = r_glob ? (i_stat.sev != SEV_NONE) : (i_stat.sev >= SEV_WARN);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_glob  = r_glob;
        n_held  = r_held;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.in_take = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.win_reset = i_stat.span_hit;
                if (close && i_stat.nonempty) begin
                    o_cmd.load_win = 1'b1;
                    n_glob         = 1'b0;
                    n_cnt          = '0;
                    n_state        = S_EVAL;
                end else if (i_stat.eos) begin
                    n_state = S_GLD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (emit) begin
                    n_state = S_PUT;
                end else if (r_glob) begin
                    if (r_held) begin
                        o_cmd.out_show = 1'b1;
                        o_cmd.out_last = 1'b1;
                        n_held         = 1'b0;
                    end
                    n_state = S_FIN;
                end else if (i_stat.eos) begin
                    n_state = S_GLD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PUT: begin
                if (r_glob && r_held) begin
                    o_cmd.out_show = 1'b1;
                    o_cmd.out_last = 1'b0;
                    n_held         = 1'b0;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_glob) begin
                        o_cmd.out_last = 1'b1;
                        n_state        = S_FIN;
                    end else if (i_stat.eos) begin
                        o_cmd.out_hold = 1'b1;
                        n_held         = 1'b1;
                        n_state        = S_GLD;
                    end else begin
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_GLD: begin
                o_cmd.load_glob = 1'b1;
                n_glob          = 1'b1;
                n_cnt           = '0;
                n_state         = S_EVAL;
            end
            S_FIN: begin
                o_cmd.clear_all = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_glob  <= 1'b0;
            r_held  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_glob  <= n_glob;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/wlbf_dpath.sv
// datapath of the flagger: running sums, cursor, shift-add threshold products,
// restoring share dividers and the output register; uses wlbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wlbf_dpath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [wlbf_pkg::KIND_W-1:0]        i_kind,
    input  wire  [wlbf_pkg::LEN_W-1:0]         i_len,
    input  wire                                i_eos,
    input  wire  [wlbf_pkg::THR_W-1:0]         i_warn_thr,
    input  wire  [wlbf_pkg::THR_W-1:0]         i_error_thr,
    input  wire  [wlbf_pkg::SUM_W-1:0]         i_span,
    input  wlbf_pkg::t_cmd                     i_cmd,
    output wlbf_pkg::t_stat                    o_stat,
    input  wire                                i_m_tready,
    output logic                               o_m_tvalid,
    output logic [wlbf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import wlbf_pkg::*;

    // latched input item
    logic [KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]  r_len;
    logic              r_eos;

    // running state
    logic [SUM_W-1:0] r_cursor, r_begin;
    logic [SUM_W-1:0] r_win_first, r_win_second, r_win_common;
    logic [SUM_W-1:0] r_glb_first, r_glb_second, r_glb_common, r_glb_side;

    // evaluation operands
    logic             r_op_glob;
    logic [SUM_W-1:0] r_op_start, r_op_end, r_op_first, r_op_second;
    logic [SUM_W-1:0] r_op_common, r_op_side, r_mx, r_dev;
    logic [SUM_W:0]   r_tot;
    logic [THR_W-1:0] r_te, r_tw;
    logic [PROD_W-1:0] r_pe, r_pw;
    logic [REM_W-1:0] r_r1, r_r2;
    logic [THR_W-1:0] r_q1, r_q2;

    // output register
    logic                  r_o_valid, r_o_held, r_o_last, r_o_glob;
    logic [OUT_DATA_W-1:0] r_o_data;

    logic [SUM_W-1:0]  ld_first, ld_second;
    logic [SUM_W-1:0]  diff;
    logic [REM_W-1:0]  tot_ext, sh1, sh2;
    logic [CMP_W-1:0]  dev_e, dev_n, pe_e, pw_e;
    logic [SEV_W-1:0]  sev;
    logic [FRAC_W-1:0] share1, share2;

    assign diff = r_cursor - r_begin;

    assign o_stat.span_hit = (diff >= i_span);
    assign o_stat.nonempty = (r_cursor != r_begin);
    assign o_stat.eos      = r_eos;
    assign o_stat.sev      = sev;
    assign o_stat.out_free = (!r_o_valid || i_m_tready) && !r_o_held;

    assign ld_first  = i_cmd.load_glob ? r_glb_first  : r_win_first;
    assign ld_second = i_cmd.load_glob ? r_glb_second : r_win_second;

    assign tot_ext = {1'b0, r_tot};
    assign sh1     = {r_r1[REM_W-2:0], 1'b0};
    assign sh2     = {r_r2[REM_W-2:0], 1'b0};

    // deviation scaled by 2^FRAC_W and 2^(FRAC_W+1) against threshold products
    assign dev_e = {{(CMP_W - SUM_W - FRAC_W){1'b0}}, r_dev, {FRAC_W{1'b0}}};
    assign dev_n = {{(CMP_W - SUM_W - THR_W){1'b0}}, r_dev, {THR_W{1'b0}}};
    assign pe_e  = {1'b0, r_pe};
    assign pw_e  = {1'b0, r_pw};

    always_comb begin
        if (r_mx == '0) begin
            sev = SEV_NONE;
        end else if (dev_e > pe_e) begin
            sev = SEV_ERROR;
        end else if (dev_e > pw_e) begin
            sev = SEV_WARN;
        end else if (dev_n > pw_e) begin
            sev = SEV_NOTICE;
        end else begin
            sev = SEV_NONE;
        end
    end

    // one extra quotient bit is dropped, which also saturates at all ones
    assign share1 = (r_tot == '0) ? '0 : r_q1[THR_W-1:1];
    assign share2 = (r_tot == '0) ? '0 : r_q2[THR_W-1:1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_kind <= i_kind;
            r_len  <= i_len;
            r_eos  <= i_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_cursor     <= '0;
            r_begin      <= '0;
            r_win_first  <= '0;
            r_win_second <= '0;
            r_win_common <= '0;
            r_glb_first  <= '0;
            r_glb_second <= '0;
            r_glb_common <= '0;
            r_glb_side   <= '0;
        end else if (i_cmd.acc) begin
            r_cursor <= sat_add(r_cursor, r_len);
            unique case (r_kind)
                KIND_COMMON: begin
                    r_win_common <= sat_add(r_win_common, r_len);
                    r_glb_common <= sat_add(r_glb_common, r_len);
                end
                KIND_FIRST: begin
                    r_win_first <= sat_add(r_win_first, r_len);
                    r_glb_first <= sat_add(r_glb_first, r_len);
                end
                KIND_SECOND: begin
                    r_win_second <= sat_add(r_win_second, r_len);
                    r_glb_second <= sat_add(r_glb_second, r_len);
                end
                KIND_SIDE: begin
                    r_glb_side <= sat_add(r_glb_side, r_len);
                end
                default: begin
                end
            endcase
        end else if (i_cmd.win_reset) begin
            r_begin      <= r_cursor;
            r_win_first  <= '0;
            r_win_second <= '0;
            r_win_common <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win || i_cmd.load_glob) begin
            r_op_glob   <= i_cmd.load_glob;
            r_op_start  <= i_cmd.load_glob ? '0 : r_begin;
            r_op_end    <= i_cmd.load_glob ? '0 : r_cursor;
            r_op_first  <= ld_first;
            r_op_second <= ld_second;
            r_op_common <= i_cmd.load_glob ? r_glb_common : r_win_common;
            r_op_side   <= i_cmd.load_glob ? r_glb_side : '0;
            r_mx        <= (ld_first > ld_second) ? ld_first : ld_second;
            r_dev       <= (ld_first > ld_second) ? ld_first - ld_second
                                                  : ld_second - ld_first;
            r_tot       <= {1'b0, ld_first} + {1'b0, ld_second};
            r_te        <= i_error_thr;
            r_tw        <= i_warn_thr;
            r_pe        <= '0;
            r_pw        <= '0;
            r_r1        <= {2'b00, ld_first};
            r_r2        <= {2'b00, ld_second};
            r_q1        <= '0;
            r_q2        <= '0;
        end else if (i_cmd.step) begin
            r_te <= {r_te[THR_W-2:0], 1'b0};
            r_tw <= {r_tw[THR_W-2:0], 1'b0};
            r_pe <= {r_pe[PROD_W-2:0], 1'b0}
                    + (r_te[THR_W-1] ? {{THR_W{1'b0}}, r_mx} : '0);
            r_pw <= {r_pw[PROD_W-2:0], 1'b0}
                    + (r_tw[THR_W-1] ? {{THR_W{1'b0}}, r_mx} : '0);
            if (sh1 >= tot_ext) begin
                r_r1 <= sh1 - tot_ext;
                r_q1 <= {r_q1[THR_W-2:0], 1'b1};
            end else begin
                r_r1 <= sh1;
                r_q1 <= {r_q1[THR_W-2:0], 1'b0};
            end
            if (sh2 >= tot_ext) begin
                r_r2 <= sh2 - tot_ext;
                r_q2 <= {r_q2[THR_W-2:0], 1'b1};
            end else begin
                r_r2 <= sh2;
                r_q2 <= {r_q2[THR_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_held  <= 1'b0;
            r_o_last  <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= !i_cmd.out_hold;
            r_o_held  <= i_cmd.out_hold;
            r_o_last  <= i_cmd.out_last;
        end else if (i_cmd.out_show) begin
            r_o_valid <= 1'b1;
            r_o_held  <= 1'b0;
            r_o_last  <= i_cmd.out_last;
        end else if (r_o_valid && i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_glob <= r_op_glob;
            r_o_data <= {{(OUT_DATA_W - OUT_FLD_W){1'b0}},
                         r_op_side, r_op_common, r_op_second, r_op_first, sev,
                         share2, share1, r_op_end, r_op_start};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_glob;
    assign o_m_tlast  = r_o_last;

endmodule

`default_nettype wire

### hw/rtl/windowed_length_balance_flagger_top.sv
// a segment that closes no nonempty window is accumulated and checked before the next is taken;
// closing a nonempty window runs 17 shift-add product and share division steps side by side
// and a decision, then loads a flag when the output is free; output stalls delay that flag
// end of stream grades the last window (skipped when empty) and then the global totals, and
// a held window flag is shown in front of the global flag; one segment in flight
// reset (synchronous, active low) clears all sums, the cursor and loads default thresholds
`timescale 1ns / 1ps
`default_nettype none

module windowed_length_balance_flagger_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // slave stream
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [wlbf_pkg::IN_DATA_W-1:0]     i_s_tdata,  // segment_kind, segment_length
    input  wire                                i_s_tlast,  // end_of_stream
    // master stream
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // window_start, end_bp, first_share, second_share, severity,
    // first_total, second_total, common_total, arm_total
    output logic [wlbf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tuser,  // is_global
    output logic                               o_m_tlast,  // last_of_run
    // configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [4:0]                         paddr,
    input  wire  [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);
    import wlbf_pkg::*;

    logic [THR_W-1:0] r_warn_thr, r_error_thr;
    logic [SUM_W-1:0] r_span;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_thr  <= WARN_RESET;
            r_error_thr <= ERROR_RESET;
            r_span      <= SPAN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_WARN:  r_warn_thr  <= pwdata[THR_W-1:0];
                REG_ERROR: r_error_thr <= pwdata[THR_W-1:0];
                REG_SPAN:  r_span      <= pwdata[SUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_WARN:  prdata = {{(64 - THR_W){1'b0}}, r_warn_thr};
            REG_ERROR: prdata = {{(64 - THR_W){1'b0}}, r_error_thr};
            REG_SPAN:  prdata = {{(64 - SUM_W){1'b0}}, r_span};
            default:   prdata = '0;
        endcase
    end

    wlbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wlbf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_s_tdata[KIND_W-1:0]),
        .i_len       (i_s_tdata[KIND_W+LEN_W-1:KIND_W]),
        .i_eos       (i_s_tlast),
        .i_warn_thr  (r_warn_thr),
        .i_error_thr (r_error_thr),
        .i_span      (r_span),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    a_take_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken twice without processing");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !o_s_tready)
        else $error("ready while grading");

    a_window_sev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
        (o_m_tdata[2*SUM_W+2*FRAC_W+SEV_W-1:2*SUM_W+2*FRAC_W] == SEV_WARN ||
         o_m_tdata[2*SUM_W+2*FRAC_W+SEV_W-1:2*SUM_W+2*FRAC_W] == SEV_ERROR))
        else $error("window flag below warning");

endmodule

`default_nettype wire

### verif/windowed_length_balance_flagger_checker.sv
// checker for the windowed length balance flagger: follows the register port and
// the segment stream, predicts every flag transfer and compares it field by field
// depends on wlbf_pkg for widths, kind, severity and register codes
`timescale 1ns / 1ps

module windowed_length_balance_flagger_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    input  wire  [wlbf_pkg::IN_DATA_W-1:0]     i_s_tdata,  // segment_kind, segment_length
    input  wire                                i_s_tlast,  // end_of_stream
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    // window_start, end_bp, first_share, second_share, severity,
    // first_total, second_total, common_total, arm_total
    input  wire  [wlbf_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input  wire                                i_m_tuser,  // is_global
    input  wire                                i_m_tlast,  // last_of_run
    input  wire                                i_psel,
    input  wire                                i_penable,
    input  wire                                i_pwrite,
    input  wire  [4:0]                         i_paddr,
    input  wire  [63:0]                        i_pwdata,
    input  wire  [63:0]                        i_prdata,
    input  wire                                i_pready,
    output int                                 o_fail_count,
    output int                                 o_awaited
);
    import wlbf_pkg::*;

    localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};
    localparam logic [FRAC_W-1:0] SHARE_TOP = {FRAC_W{1'b1}};

    typedef struct packed {
        logic [IN_DATA_W-LEN_W-KIND_W-1:0] pad;
        logic [LEN_W-1:0]                  length;
        logic [KIND_W-1:0]                 kind;
    } t_segment_word;

    typedef struct packed {
        logic [OUT_DATA_W-OUT_FLD_W-1:0] pad;
        logic [SUM_W-1:0]                arm_total;
        logic [SUM_W-1:0]                common_total;
        logic [SUM_W-1:0]                second_total;
        logic [SUM_W-1:0]                first_total;
        logic [SEV_W-1:0]                severity;
        logic [FRAC_W-1:0]               second_share;
        logic [FRAC_W-1:0]               first_share;
        logic [SUM_W-1:0]                end_bp;
        logic [SUM_W-1:0]                window_start;
    } t_flag_word;

    typedef struct packed {
        logic       is_global;
        t_flag_word word;
        logic       last_of_run;
    } t_flag;

    t_segment_word seg_word;
    t_flag_word    out_word;

    assign seg_word = i_s_tdata;
    assign out_word = i_m_tdata;

    logic [THR_W-1:0] warn_limit;
    logic [THR_W-1:0] error_limit;
    logic [SUM_W-1:0] span;

    logic [SUM_W-1:0] cursor;
    logic [SUM_W-1:0] win_start;
    logic [SUM_W-1:0] win_first;
    logic [SUM_W-1:0] win_second;
    logic [SUM_W-1:0] win_common;
    logic [SUM_W-1:0] tot_first;
    logic [SUM_W-1:0] tot_second;
    logic [SUM_W-1:0] tot_common;
    logic [SUM_W-1:0] tot_arm;

    t_flag step_flags[$];
    t_flag awaited_flags[$];

    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
                                                     input logic [LEN_W-1:0] len);
        logic [SUM_W:0] wide;
        wide = acc;
        wide = wide + len;
        return (wide > SUM_TOP) ? SUM_TOP : wide[SUM_W-1:0];
    endfunction

    // |a-b| / max(a,b) against the thresholds, cross-multiplied
    function automatic logic [SEV_W-1:0] balance_grade(input logic [SUM_W-1:0] a,
                                                       input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] hi;
        logic [SUM_W-1:0] gap;
        logic [79:0]      scaled;
        logic [79:0]      err_prod;
        logic [79:0]      warn_prod;
        hi = (a > b) ? a : b;
        gap = (a > b) ? a - b : b - a;
        scaled = gap;
        scaled = scaled << FRAC_W;
        err_prod = error_limit;
        err_prod = err_prod * hi;
        warn_prod = warn_limit;
        warn_prod = warn_prod * hi;
        if (hi == '0)
            return SEV_NONE;
        if (scaled > err_prod)
            return SEV_ERROR;
        if (scaled > warn_prod)
            return SEV_WARN;
        if ((scaled << 1) > warn_prod)
            return SEV_NOTICE;
        return SEV_NONE;
    endfunction

    function automatic logic [FRAC_W-1:0] share_of(input logic [SUM_W-1:0] part,
                                                   input logic [SUM_W-1:0] other);
        logic [63:0] whole;
        logic [63:0] quot;
        whole = part;
        whole = whole + other;
        if (whole == 0)
            return '0;
        quot = part;
        quot = (quot << FRAC_W) / whole;
        return (quot > SHARE_TOP) ? SHARE_TOP : quot[FRAC_W-1:0];
    endfunction

    function automatic t_flag make_flag(input logic glob,
                                        input logic [SUM_W-1:0] lo_bp,
                                        input logic [SUM_W-1:0] hi_bp,
                                        input logic [SUM_W-1:0] h1,
                                        input logic [SUM_W-1:0] h2,
                                        input logic [SEV_W-1:0] sev,
                                        input logic [SUM_W-1:0] com,
                                        input logic [SUM_W-1:0] arm);
        t_flag f;
        f.is_global = glob;
        f.word = '0;
        f.word.window_start = lo_bp;
        f.word.end_bp = hi_bp;
        f.word.first_share = share_of(h1, h2);
        f.word.second_share = share_of(h2, h1);
        f.word.severity = sev;
        f.word.first_total = h1;
        f.word.second_total = h2;
        f.word.common_total = com;
        f.word.arm_total = arm;
        f.last_of_run = 1'b0;
        return f;
    endfunction

    task automatic clear_stream();
        cursor = '0;
        win_start = '0;
        win_first = '0;
        win_second = '0;
        win_common = '0;
        tot_first = '0;
        tot_second = '0;
        tot_common = '0;
        tot_arm = '0;
    endtask

    // window flags only at warning or above, and never for an empty window
    task automatic close_window();
        logic [SEV_W-1:0] sev;
        sev = balance_grade(win_first, win_second);
        if (cursor > win_start && sev >= SEV_WARN)
            step_flags = {step_flags, make_flag(1'b0, win_start, cursor, win_first,
                                                win_second, sev, win_common, '0)};
    endtask

    task automatic absorb_segment(input logic [KIND_W-1:0] kind,
                                  input logic [LEN_W-1:0] len,
                                  input logic eos);
        logic [SEV_W-1:0] sev;
        t_flag            f;
        step_flags.delete();
        case (kind)
            KIND_COMMON: begin
                win_common = add_clamped(win_common, len);
                tot_common = add_clamped(tot_common, len);
            end
            KIND_FIRST: begin
                win_first = add_clamped(win_first, len);
                tot_first = add_clamped(tot_first, len);
            end
            KIND_SECOND: begin
                win_second = add_clamped(win_second, len);
                tot_second = add_clamped(tot_second, len);
            end
            KIND_SIDE: begin
                tot_arm = add_clamped(tot_arm, len);
            end
            default: ;
        endcase
        cursor = add_clamped(cursor, len);
        if (cursor - win_start >= span) begin
            close_window();
            win_start = cursor;
            win_first = '0;
            win_second = '0;
            win_common = '0;
        end
        if (eos) begin
            close_window();
            sev = balance_grade(tot_first, tot_second);
            if (sev != SEV_NONE)
                step_flags = {step_flags, make_flag(1'b1, '0, '0, tot_first, tot_second,
                                                    sev, tot_common, tot_arm)};
            clear_stream();
        end
        for (int k = 0; k < step_flags.size(); k++) begin
            f = step_flags[k];
            f.last_of_run = (k == step_flags.size() - 1);
            awaited_flags = {awaited_flags, f};
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_flag();
        t_flag want;
        if (awaited_flags.size() == 0) begin
            $error("flag transfer with no flag expected");
            o_fail_count++;
        end else begin
            want = awaited_flags.pop_front();
            check_field("is_global", want.is_global, i_m_tuser);
            check_field("window_start", want.word.window_start, out_word.window_start);
            check_field("end_bp", want.word.end_bp, out_word.end_bp);
            check_field("first_share", want.word.first_share, out_word.first_share);
            check_field("second_share", want.word.second_share, out_word.second_share);
            check_field("severity", want.word.severity, out_word.severity);
            check_field("first_total", want.word.first_total, out_word.first_total);
            check_field("second_total", want.word.second_total, out_word.second_total);
            check_field("common_total", want.word.common_total, out_word.common_total);
            check_field("arm_total", want.word.arm_total, out_word.arm_total);
            check_field("tdata padding", want.word.pad, out_word.pad);
            check_field("last_of_run", want.last_of_run, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            warn_limit = WARN_RESET;
            error_limit = ERROR_RESET;
            span = SPAN_RESET;
            clear_stream();
            awaited_flags.delete();
            o_fail_count = 0;
            o_awaited = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[4:3])
                        REG_WARN:  warn_limit = i_pwdata[THR_W-1:0];
                        REG_ERROR: error_limit = i_pwdata[THR_W-1:0];
                        REG_SPAN:  span = i_pwdata[SUM_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (i_paddr[4:3])
                        REG_WARN:  check_field("warn_threshold read", warn_limit, i_prdata);
                        REG_ERROR: check_field("error_threshold read", error_limit, i_prdata);
                        REG_SPAN:  check_field("window_span read", span, i_prdata);
                        default: ;
                    endcase
                end
            end
            if (i_s_tvalid && i_s_tready)
                absorb_segment(seg_word.kind, seg_word.length, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                compare_flag();
            o_awaited = awaited_flags.size();
        end
    end

endmodule

### verif/windowed_length_balance_flagger_top_tb.sv
// testbench top for windowed_length_balance_flagger_top: clock, reset, register
// writes, segment streams and flag-side back-pressure; checking lives in the checker
// depends on wlbf_pkg, the block and windowed_length_balance_flagger_checker
`timescale 1ns / 1ps

module windowed_length_balance_flagger_top_tb;
    import wlbf_pkg::*;

    localparam logic [1:0]        REG_SPARE  = 2'd3;
    localparam logic [KIND_W-1:0] KIND_LOOSE = 3'd4;
    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [SUM_W-1:0]  SPAN_MAX   = {SUM_W{1'b1}};
    localparam logic [THR_W-1:0]  THR_ONE    = 17'd65536;
    localparam logic [THR_W-1:0]  THR_MAX    = {THR_W{1'b1}};
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 600;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    wire                   o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // segment_kind, segment_length
    logic                  i_s_tlast;   // end_of_stream
    wire                   o_m_tvalid;
    logic                  i_m_tready;
    // window_start, end_bp, first_share, second_share, severity,
    // first_total, second_total, common_total, arm_total
    wire  [OUT_DATA_W-1:0] o_m_tdata;
    wire                   o_m_tuser;   // is_global
    wire                   o_m_tlast;   // last_of_run
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [4:0]            paddr;
    logic [63:0]           pwdata;
    wire  [63:0]           prdata;
    wire                   pready;

    int   fail_count;
    int   awaited;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    logic hold_done;

    windowed_length_balance_flagger_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    windowed_length_balance_flagger_checker flag_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("windowed_length_balance_flagger_top_tb failed");
        $finish;
    end

    // flag side: random stalls plus one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_access(input logic write, input logic [1:0] idx,
                              input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [63:0] value);
        apb_access(1'b1, idx, value);
        apb_access(1'b0, idx, '0);
    endtask

    task automatic configure(input logic [THR_W-1:0] warn, input logic [THR_W-1:0] err,
                             input logic [SUM_W-1:0] span);
        set_register(REG_WARN, warn);
        set_register(REG_ERROR, err);
        set_register(REG_SPAN, span);
    endtask

    task automatic send_segment(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                                input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(IN_DATA_W - LEN_W - KIND_W){1'b0}}, len, kind};
        i_s_tlast <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // whole streams ending in end of stream, with a random haplotype skew each
    task automatic run_streams(input int item_goal, input int len_cap);
        int               sent;
        int               run_len;
        int               pick;
        int               skew;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        sent = 0;
        while (sent < item_goal) begin
            run_len = $urandom_range(1, 12);
            skew = $urandom_range(0, 100);
            for (int k = 0; k < run_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    kind = KIND_COMMON;
                else if (pick < 80)
                    kind = ($urandom_range(0, 99) < skew) ? KIND_FIRST : KIND_SECOND;
                else if (pick < 88)
                    kind = KIND_SIDE;
                else
                    kind = KIND_LOOSE + KIND_W'($urandom_range(0, 3));
                case ($urandom_range(0, 15))
                    0: len = '0;
                    1: len = LEN_MAX;
                    2: len = $urandom;
                    default: len = $urandom_range(0, len_cap);
                endcase
                send_segment(kind, len, k == run_len - 1);
            end
            sent += run_len;
        end
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values, then hand-picked segments on a short window
        apb_access(1'b0, REG_WARN, '0);
        apb_access(1'b0, REG_ERROR, '0);
        apb_access(1'b0, REG_SPAN, '0);
        configure(WARN_RESET, ERROR_RESET, 100);
        send_segment(KIND_FIRST, '0, 1'b0);
        send_segment(KIND_FIRST, 60, 1'b0);
        send_segment(KIND_SECOND, 20, 1'b0);
        send_segment(KIND_COMMON, 30, 1'b0);
        send_segment(KIND_SIDE, 7, 1'b0);
        for (int k = KIND_LOOSE; k < 2 ** KIND_W; k++)
            send_segment(KIND_W'(k), LEN_W'(k), 1'b0);
        send_segment(KIND_FIRST, 40, 1'b0);
        send_segment(KIND_SECOND, 35, 1'b1);
        // shared only: both haplotype totals zero
        send_segment(KIND_COMMON, 50, 1'b0);
        send_segment(KIND_COMMON, 60, 1'b1);
        // window flag and global flag from one segment
        send_segment(KIND_FIRST, LEN_MAX, 1'b0);
        send_segment(KIND_SECOND, 1, 1'b1);
        // empty last window
        send_segment(KIND_SECOND, 100, 1'b0);
        send_segment(KIND_FIRST, 0, 1'b1);
        // just over notice, then just over warning
        send_segment(KIND_FIRST, 10, 1'b0);
        send_segment(KIND_SECOND, 9, 1'b0);
        send_segment(KIND_LOOSE, 0, 1'b1);
        send_segment(KIND_FIRST, 5, 1'b0);
        send_segment(KIND_SECOND, 4, 1'b1);
        settle();

        configure(WARN_RESET, ERROR_RESET, $urandom_range(200, 5000));
        run_streams(100, 300);
        settle();

        send_idle_pct = 52;
        configure('0, THR_ONE, 1);
        run_streams(80, 50);
        settle();

        send_idle_pct = 0;
        recv_stall_pct = 52;
        configure(THR_ONE, '0, '0);
        set_register(REG_SPARE, '1);
        run_streams(80, 1000);
        settle();

        send_idle_pct = 16;
        recv_stall_pct = 16;
        configure(THR_W'($urandom_range(0, 65536)), THR_W'($urandom_range(0, 65536)),
                  $urandom_range(1 << 16, 1 << 22));
        hold_req = 1'b1;
        run_streams(90, 1 << 18);
        settle();

        // drive sums and cursor into saturation
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(THR_W'($urandom_range(0, 65536)), THR_MAX, SPAN_MAX);
        repeat (260) send_segment(KIND_FIRST, LEN_MAX, 1'b0);
        send_segment(KIND_COMMON, LEN_MAX, 1'b0);
        send_segment(KIND_SIDE, LEN_MAX, 1'b0);
        send_segment(KIND_LOOSE, LEN_MAX, 1'b0);
        send_segment(KIND_SECOND, LEN_MAX, 1'b1);
        settle();

        if (fail_count == 0)
            $display("windowed_length_balance_flagger_top_tb passed");
        else
            $display("windowed_length_balance_flagger_top_tb failed");
        $finish;
    end

endmodule
